// ----- design/ssp_pkg.sv -----
package ssp_pkg;

  localparam int POSE_LEN = 9;
  localparam int Q_W = 32;
  localparam int AMT_W = 17;
  localparam int MUL_W = AMT_W + 1;
  localparam int LANE_ACC_W = Q_W + 2;
  localparam int CNT_W = 5;
  localparam int DIV_STEPS = 16;
  localparam int MUL_STEPS = 17;

  localparam int IN_TDATA_W = 11 * Q_W;
  localparam int OUT_TDATA_W = POSE_LEN * Q_W;
  localparam int MOVE_LSB = 9 * Q_W;
  localparam int TICK_LSB = 10 * Q_W;
  localparam int SCALE_FIRST = 6;

  localparam logic [AMT_W-1:0] Q_ONE = 17'h10000;
  localparam logic [MUL_W-1:0] EASE_K = 18'h30000;
  localparam logic [Q_W-1:0] SCALE_ONE = 32'h0001_0000;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef logic signed [Q_W-1:0] qval_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CMP  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_SQR  = 7'b0001000,
    ST_EAS  = 7'b0010000,
    ST_BLD  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

endpackage

// ----- design/ssp_lane.sv -----
module ssp_lane import ssp_pkg::*; (
  input  logic  clk,
  input  logic  clr,
  input  logic  step,
  input  logic  mbit,
  input  qval_t from_val,
  input  qval_t to_val,
  output qval_t res
);

  logic signed [Q_W:0] diff;
  logic signed [LANE_ACC_W-1:0] hi_r;
  logic signed [LANE_ACC_W:0] sum;

  assign diff = $signed({to_val[Q_W-1], to_val}) - $signed({from_val[Q_W-1], from_val});

  // shift-add, multiplier bits lsb first; sum holds product >> 16 on the last bit
  assign sum = $signed({hi_r[LANE_ACC_W-1], hi_r})
             + (mbit ? $signed({{2{diff[Q_W]}}, diff}) : '0);

  assign res = from_val + qval_t'(sum[Q_W-1:0]);

  always_ff @(posedge clk) begin
    if (clr) begin
      hi_r <= '0;
    end else if (step) begin
      hi_r <= sum[LANE_ACC_W:1];
    end
  end

endmodule

// ----- design/smoothstep_pose_interpolator.sv -----
// path: a start word, or a tick while idle, goes from ST_IDLE straight to ST_OUT; a tick
// during a motion runs ST_CMP, the bit-serial divider in ST_DIV (skipped when the motion
// ends on that tick) and three multiply passes, ST_SQR, ST_EAS and ST_BLD, before ST_OUT
// one word at a time: in_tready is high only in ST_IDLE, and ST_OUT waits for a free output
// reset: synchronous active-low rst_n; pose returns to zero with scale 1.0, motion clears
module smoothstep_pose_interpolator import ssp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // goal_pos_x/y/z, goal_rot_x/y/z, goal_size_x/y/z, move_time, tick_time
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pos_x/y/z, rot_x/y/z, size_x/y/z
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // moving
  output logic [0:0]             out_tuser
);

  state_t state_r;
  qval_t pose_now_r [POSE_LEN];
  qval_t from_r [POSE_LEN];
  qval_t to_r [POSE_LEN];
  qval_t lane_res [POSE_LEN];
  logic [Q_W-1:0] spent_r, total_r, rem_r, move_time, tick_time, rem_nxt;
  logic motion_r;
  logic [AMT_W-1:0] amt_r, div_amt, eased;
  logic [Q_W:0] spent_sum;
  logic [Q_W:0] rem_sh;
  logic q_bit;
  logic [MUL_W-1:0] mcand_r, acc_r;
  logic [AMT_W-1:0] mplier_r;
  logic [MUL_W:0] mul_sum;
  logic [CNT_W-1:0] cnt_r;
  logic out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic out_tuser_r;
  logic accept, div_last, mul_last, lane_clr, lane_step;

  assign in_tready = (state_r == ST_IDLE);
  assign accept = in_tvalid & in_tready;
  assign move_time = in_tdata[MOVE_LSB +: Q_W];
  assign tick_time = in_tdata[TICK_LSB +: Q_W];

  assign spent_sum = {1'b0, spent_r} + {1'b0, tick_time};

  // restoring division, one quotient bit per cycle; remainder stays below total
  assign rem_sh = {rem_r, 1'b0};
  assign q_bit = (rem_sh >= {1'b0, total_r});
  assign rem_nxt = q_bit ? Q_W'(rem_sh - {1'b0, total_r}) : rem_sh[Q_W-1:0];
  assign div_amt = {amt_r[AMT_W-2:0], q_bit};

  // shared unsigned shift-add multiplier; on the last bit mul_sum is product >> 16
  assign mul_sum = {1'b0, acc_r} + (mplier_r[0] ? {1'b0, mcand_r} : '0);
  assign eased = (mul_sum > {2'b00, Q_ONE}) ? Q_ONE : mul_sum[AMT_W-1:0];

  assign div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign mul_last = (cnt_r == CNT_W'(MUL_STEPS - 1));
  assign lane_clr = (state_r == ST_EAS) && mul_last;
  assign lane_step = (state_r == ST_BLD);

  for (genvar g = 0; g < POSE_LEN; g++) begin : g_lane
    ssp_lane u_lane (
      .clk      (clk),
      .clr      (lane_clr),
      .step     (lane_step),
      .mbit     (mplier_r[0]),
      .from_val (from_r[g]),
      .to_val   (to_r[g]),
      .res      (lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      motion_r <= 1'b0;
      spent_r <= '0;
      total_r <= '0;
      out_tvalid_r <= 1'b0;
      cnt_r <= '0;
      for (int i = 0; i < POSE_LEN; i++) begin
        pose_now_r[i] <= (i >= SCALE_FIRST) ? SCALE_ONE : '0;
        from_r[i] <= '0;
        to_r[i] <= '0;
      end
    end else begin
      // a new word loaded in ST_OUT keeps the valid high
      if (out_tvalid_r && out_tready && (state_r != ST_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_tuser[0] == ACT_START) begin
              state_r <= ST_OUT;
              if (move_time == '0) begin
                for (int i = 0; i < POSE_LEN; i++) begin
                  pose_now_r[i] <= in_tdata[i*Q_W +: Q_W];
                end
                motion_r <= 1'b0;
              end else begin
                for (int i = 0; i < POSE_LEN; i++) begin
                  from_r[i] <= pose_now_r[i];
                  to_r[i] <= in_tdata[i*Q_W +: Q_W];
                end
                spent_r <= '0;
                total_r <= move_time;
                motion_r <= 1'b1;
              end
            end else if (motion_r) begin
              spent_r <= spent_sum[Q_W] ? '1 : spent_sum[Q_W-1:0];
              state_r <= ST_CMP;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_CMP: begin
          cnt_r <= '0;
          if (spent_r >= total_r) begin
            // motion reaches its end: amount clamps to one
            amt_r <= Q_ONE;
            mcand_r <= {1'b0, Q_ONE};
            mplier_r <= Q_ONE;
            acc_r <= '0;
            motion_r <= 1'b0;
            state_r <= ST_SQR;
          end else begin
            rem_r <= spent_r;
            amt_r <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          amt_r <= div_amt;
          if (div_last) begin
            cnt_r <= '0;
            mcand_r <= {1'b0, div_amt};
            mplier_r <= div_amt;
            acc_r <= '0;
            state_r <= ST_SQR;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_SQR: begin
          if (mul_last) begin
            cnt_r <= '0;
            mcand_r <= EASE_K - {amt_r, 1'b0};
            mplier_r <= mul_sum[AMT_W-1:0];
            acc_r <= '0;
            state_r <= ST_EAS;
          end else begin
            acc_r <= mul_sum[MUL_W:1];
            mplier_r <= mplier_r >> 1;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_EAS: begin
          if (mul_last) begin
            cnt_r <= '0;
            mplier_r <= eased;
            state_r <= ST_BLD;
          end else begin
            acc_r <= mul_sum[MUL_W:1];
            mplier_r <= mplier_r >> 1;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_BLD: begin
          mplier_r <= mplier_r >> 1;
          if (mul_last) begin
            cnt_r <= '0;
            for (int i = 0; i < POSE_LEN; i++) begin
              pose_now_r[i] <= lane_res[i];
            end
            state_r <= ST_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_OUT: begin
          // result word waits here until the output register is free
          if (!out_tvalid_r || out_tready) begin
            for (int i = 0; i < POSE_LEN; i++) begin
              out_tdata_r[i*Q_W +: Q_W] <= pose_now_r[i];
            end
            out_tuser_r <= motion_r;
            out_tvalid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

// ----- design/ssp_checker.sv -----
module ssp_checker import ssp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [0:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser
);

  logic in_acc;
  logic snap_start, timed_start;

  assign in_acc = in_tvalid && in_tready;
  assign snap_start = in_acc && !out_tvalid && (in_tuser[0] == ACT_START)
                    && (in_tdata[MOVE_LSB +: Q_W] == '0);
  assign timed_start = in_acc && !out_tvalid && (in_tuser[0] == ACT_START)
                     && (in_tdata[MOVE_LSB +: Q_W] != '0);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // one word at a time: no second accept right after one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while previous word in flight");

  // zero duration start snaps the pose to the goal and stops motion
  a_snap: assert property (@(posedge clk) disable iff (!rst_n)
    snap_start |=> ##1 (out_tvalid && (out_tuser[0] == 1'b0)
                        && (out_tdata == $past(in_tdata[OUT_TDATA_W-1:0], 2))))
    else $error("snap start gave wrong pose");

  // timed start reports motion in progress
  a_timed: assert property (@(posedge clk) disable iff (!rst_n)
    timed_start |=> ##1 (out_tvalid && (out_tuser[0] == 1'b1)))
    else $error("timed start did not report motion");

endmodule

bind smoothstep_pose_interpolator ssp_checker u_ssp_checker (.*);
